### hdl/temd_pkg.sv
`timescale 1ns / 1ps
// Package for the terminal escape and mouse report demultiplexer.
// Holds shared types, codes and constants; no dependencies.
package temd_pkg;

  // Longest report body held before the report is dropped
  localparam int REPORT_LIMIT = 63;
  localparam int LEN_W        = $clog2(REPORT_LIMIT + 1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam int FIELD_W      = 11;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 11'd2047;

  localparam logic [7:0] BYTE_ESC      = 8'h1b;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
  localparam logic [7:0] BYTE_LESS     = 8'h3c;
  localparam logic [7:0] BYTE_FINAL_UP = 8'h4d;
  localparam logic [7:0] BYTE_FINAL_LO = 8'h6d;
  localparam logic [7:0] BYTE_SEMI     = 8'h3b;
  localparam logic [7:0] BYTE_ZERO     = 8'h30;
  localparam logic [7:0] BYTE_NINE     = 8'h39;

  // Input opcodes
  localparam logic OPC_BYTE = 1'b0;
  localparam logic OPC_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_FLUSH = 2'd1;
  localparam logic [1:0] KIND_PRESS = 2'd2;
  localparam logic [1:0] KIND_MOVE  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_CELL_W  = 3'd0;
  localparam logic [2:0] CFG_CELL_H  = 3'd1;
  localparam logic [2:0] CFG_ORG_COL = 3'd2;
  localparam logic [2:0] CFG_ORG_ROW = 3'd3;
  localparam logic [2:0] CFG_IMG_W   = 3'd4;
  localparam logic [2:0] CFG_IMG_H   = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT = 3'd6;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_CSI,
    MODE_MOUSE
  } mode_t;

  typedef enum logic [2:0] {
    OP_KEY,        // one key byte
    OP_ESC_KEY,    // ESC, then byte
    OP_CSI_KEY,    // ESC, '[', then byte
    OP_FLUSH_ESC,  // lone escape flush
    OP_FLUSH_CSI,  // ESC, '[' on timeout
    OP_MOUSE       // pointer event
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [7:0]         data;
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] row;
    logic               press;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  cell_w;
    logic [6:0]  cell_h;
    logic [9:0]  org_col;
    logic [9:0]  org_row;
    logic [12:0] img_w;
    logic [12:0] img_h;
    logic [7:0]  timeout;
  } cfg_t;

endpackage

### hdl/temd_front.sv
`timescale 1ns / 1ps
// Front end: escape/CSI/report parser, one transaction per cycle while take is high.
// Emits at most one command per item into the queue. Depends on temd_pkg.
module temd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic          opcode,
  input  logic [7:0]    data_byte,
  input  logic [7:0]    timeout,
  output logic          push,
  output temd_pkg::cmd_t cmd
);
  import temd_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [1:0]         fidx_r, fidx_nxt;
  logic               has_dig_r, has_dig_nxt;
  logic               bad_r, bad_nxt;
  logic [FIELD_W-1:0] btn_r, btn_nxt;
  logic [FIELD_W-1:0] col_r, col_nxt;
  logic [FIELD_W-1:0] row_r, row_nxt;

  logic               is_tick;
  logic [7:0]         pend_inc;
  logic               timed_out;
  logic               is_final;
  logic               report_ok;
  logic               room;
  logic               is_digit;
  logic [FIELD_W-1:0] fld_cur;
  logic [14:0]        fld_sum;
  logic [FIELD_W-1:0] fld_sat;

  assign is_tick   = (opcode == OPC_TICK);
  assign pend_inc  = (pend_r == 8'hff) ? pend_r : pend_r + 8'd1;
  assign timed_out = (pend_inc >= timeout);
  assign is_final  = (data_byte == BYTE_FINAL_UP) || (data_byte == BYTE_FINAL_LO);
  assign report_ok = !bad_r && (fidx_r == 2'd2) && has_dig_r;
  assign room      = (len_r < LEN_W'(REPORT_LIMIT));
  assign is_digit  = (data_byte >= BYTE_ZERO) && (data_byte <= BYTE_NINE);

  always_comb begin
    case (fidx_r)
      2'd0:    fld_cur = btn_r;
      2'd1:    fld_cur = col_r;
      default: fld_cur = row_r;
    endcase
  end

  // times ten as two shifts, plus the digit
  assign fld_sum = {1'b0, fld_cur, 3'b000} + {3'b000, fld_cur, 1'b0}
                 + {11'd0, 4'(data_byte - BYTE_ZERO)};
  assign fld_sat = (fld_sum > {4'd0, FIELD_MAX}) ? FIELD_MAX : fld_sum[FIELD_W-1:0];

  // Next mode
  always_comb begin
    mode_nxt = mode_r;
    if (take) begin
      if (is_tick) begin
        if ((mode_r == MODE_ESCAPE || mode_r == MODE_CSI) && timed_out) begin
          mode_nxt = MODE_NORMAL;
        end
      end else begin
        case (mode_r)
          MODE_NORMAL: if (data_byte == BYTE_ESC) mode_nxt = MODE_ESCAPE;
          MODE_ESCAPE: mode_nxt = (data_byte == BYTE_LBRACKET) ? MODE_CSI : MODE_NORMAL;
          MODE_CSI:    mode_nxt = (data_byte == BYTE_LESS) ? MODE_MOUSE : MODE_NORMAL;
          MODE_MOUSE:  if (is_final || !room) mode_nxt = MODE_NORMAL;
          default:     mode_nxt = MODE_NORMAL;
        endcase
      end
    end
  end

  // Commands and report datapath
  always_comb begin
    push        = 1'b0;
    cmd.op      = OP_KEY;
    cmd.data    = data_byte;
    cmd.column  = col_r;
    cmd.row     = row_r;
    cmd.press   = (data_byte == BYTE_FINAL_UP) && (btn_r[1:0] == 2'b00) && !btn_r[5];
    pend_nxt    = pend_r;
    len_nxt     = len_r;
    fidx_nxt    = fidx_r;
    has_dig_nxt = has_dig_r;
    bad_nxt     = bad_r;
    btn_nxt     = btn_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (take) begin
      if (is_tick) begin
        if (mode_r == MODE_ESCAPE || mode_r == MODE_CSI) begin
          pend_nxt = pend_inc;
          if (timed_out) begin
            push     = 1'b1;
            cmd.op   = (mode_r == MODE_ESCAPE) ? OP_FLUSH_ESC : OP_FLUSH_CSI;
            pend_nxt = '0;
          end
        end
      end else begin
        case (mode_r)
          MODE_NORMAL: begin
            if (data_byte == BYTE_ESC) pend_nxt = '0;
            else push = 1'b1;
          end
          MODE_ESCAPE: begin
            if (data_byte != BYTE_LBRACKET) begin
              push   = 1'b1;
              cmd.op = OP_ESC_KEY;
            end
          end
          MODE_CSI: begin
            if (data_byte == BYTE_LESS) begin
              len_nxt = '0; fidx_nxt = '0; has_dig_nxt = 1'b0; bad_nxt = 1'b0;
              btn_nxt = '0; col_nxt = '0; row_nxt = '0;
            end else begin
              push   = 1'b1;
              cmd.op = OP_CSI_KEY;
            end
          end
          MODE_MOUSE: begin
            if (is_final || !room) begin
              push    = is_final && report_ok;
              cmd.op  = OP_MOUSE;
              len_nxt = '0; fidx_nxt = '0; has_dig_nxt = 1'b0; bad_nxt = 1'b0;
              btn_nxt = '0; col_nxt = '0; row_nxt = '0;
            end else begin
              len_nxt = len_r + LEN_W'(1);
              if (is_digit) begin
                has_dig_nxt = 1'b1;
                case (fidx_r)
                  2'd0:    btn_nxt = fld_sat;
                  2'd1:    col_nxt = fld_sat;
                  default: row_nxt = fld_sat;
                endcase
              end else if (data_byte == BYTE_SEMI) begin
                if (!has_dig_r || fidx_r >= 2'd2) begin
                  bad_nxt = 1'b1;
                end else begin
                  fidx_nxt    = fidx_r + 2'd1;
                  has_dig_nxt = 1'b0;
                end
              end else begin
                bad_nxt = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      pend_r    <= '0;
      len_r     <= '0;
      fidx_r    <= '0;
      has_dig_r <= 1'b0;
      bad_r     <= 1'b0;
      btn_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      mode_r    <= mode_nxt;
      pend_r    <= pend_nxt;
      len_r     <= len_nxt;
      fidx_r    <= fidx_nxt;
      has_dig_r <= has_dig_nxt;
      bad_r     <= bad_nxt;
      btn_r     <= btn_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule

### hdl/temd_queue.sv
`timescale 1ns / 1ps
// Command queue between parser front end and result back end.
// Register-based FIFO of QUEUE_DEPTH entries. Depends on temd_pkg.
module temd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  temd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output temd_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import temd_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = do_pop  ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_r] <= push_cmd;
  end

endmodule

### hdl/temd_back.sv
`timescale 1ns / 1ps
// Back end: expands queued commands into results, one per cycle while the output
// is not stalled, and computes clamped pointer positions. Depends on temd_pkg.
module temd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  temd_pkg::cfg_t     cfg,
  input  temd_pkg::cmd_t     head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_key_byte,
  output logic signed [16:0] out_pointer_x,
  output logic signed [16:0] out_pointer_y,
  output logic               out_last_of_run
);
  import temd_pkg::*;

  function automatic logic signed [16:0] clamp_pos(logic signed [19:0] p, logic [12:0] lim);
    logic signed [19:0] top;
    logic signed [19:0] r;
    top = $signed({7'd0, lim}) - 20'sd1;
    r   = p;
    if (lim != 13'd0) begin
      if (r < 20'sd0) r = 20'sd0;
      if (r > top)    r = top;
    end else begin
      if (r < -20'sd65536) r = -20'sd65536;
      if (r > 20'sd65535)  r = 20'sd65535;
    end
    return r[16:0];
  endfunction

  // Current command
  logic               cur_valid_r, cur_valid_nxt;
  cmd_op_t            cur_op_r;
  logic [7:0]         cur_data_r;
  logic               cur_press_r;
  logic [1:0]         step_r, step_nxt;
  logic signed [19:0] xp_r, yp_r;

  // Output register
  logic               ov_r, ov_nxt;
  logic [1:0]         kind_r;
  logic [7:0]         key_r;
  logic signed [16:0] px_r, py_r;
  logic               last_r;

  logic               advance, cur_last, load_cur;
  logic [1:0]         last_step;
  logic [1:0]         e_kind;
  logic [7:0]         e_key;
  logic signed [16:0] e_x, e_y;
  logic signed [11:0] dx, dy;
  logic signed [19:0] prod_x, prod_y;

  assign dx     = $signed({1'b0, head.column}) - $signed({2'b00, cfg.org_col});
  assign dy     = $signed({1'b0, head.row})    - $signed({2'b00, cfg.org_row});
  assign prod_x = dx * $signed({1'b0, cfg.cell_w});
  assign prod_y = dy * $signed({1'b0, cfg.cell_h});

  always_comb begin
    case (cur_op_r)
      OP_ESC_KEY:   last_step = 2'd1;
      OP_CSI_KEY:   last_step = 2'd2;
      OP_FLUSH_CSI: last_step = 2'd1;
      default:      last_step = 2'd0;
    endcase
  end

  assign advance  = cur_valid_r && (!ov_r || !out_stall);
  assign cur_last = (step_r == last_step);
  assign load_cur = !cur_valid_r || (advance && cur_last);
  assign pop      = load_cur && !empty;

  // Result for the current step
  always_comb begin
    e_kind = KIND_KEY;
    e_key  = cur_data_r;
    e_x    = '0;
    e_y    = '0;
    case (cur_op_r)
      OP_KEY: e_key = cur_data_r;
      OP_ESC_KEY: e_key = (step_r == 2'd0) ? BYTE_ESC : cur_data_r;
      OP_CSI_KEY: begin
        case (step_r)
          2'd0:    e_key = BYTE_ESC;
          2'd1:    e_key = BYTE_LBRACKET;
          default: e_key = cur_data_r;
        endcase
      end
      OP_FLUSH_ESC: begin
        e_kind = KIND_FLUSH;
        e_key  = BYTE_ESC;
      end
      OP_FLUSH_CSI: e_key = (step_r == 2'd0) ? BYTE_ESC : BYTE_LBRACKET;
      OP_MOUSE: begin
        e_kind = cur_press_r ? KIND_PRESS : KIND_MOVE;
        e_key  = '0;
        e_x    = clamp_pos(xp_r, cfg.img_w);
        e_y    = clamp_pos(yp_r, cfg.img_h);
      end
      default: ;
    endcase
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (advance) step_nxt = step_r + 2'd1;
    if (load_cur) begin
      cur_valid_nxt = !empty;
      step_nxt      = '0;
    end
    ov_nxt = ov_r;
    if (advance)                 ov_nxt = 1'b1;
    else if (ov_r && !out_stall) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      ov_r        <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_op_r    <= head.op;
      cur_data_r  <= head.data;
      cur_press_r <= head.press;
      xp_r        <= prod_x;
      yp_r        <= prod_y;
    end
    if (advance) begin
      kind_r <= e_kind;
      key_r  <= e_key;
      px_r   <= e_x;
      py_r   <= e_y;
      last_r <= cur_last;
    end
  end

  assign out_valid       = ov_r;
  assign out_kind        = kind_r;
  assign out_key_byte    = key_r;
  assign out_pointer_x   = px_r;
  assign out_pointer_y   = py_r;
  assign out_last_of_run = last_r;

endmodule

### hdl/terminal_escape_mouse_demux_unit.sv
`timescale 1ns / 1ps
// Terminal escape / SGR mouse report demultiplexer, top level.
// Path: queue entry, back end current command register, output register.
// Throughput: one transaction per cycle while in_stall is low; the back end gives
// one result per cycle while not stalled; an item causes up to three results.
// Reset: synchronous, active low; clears parser state, queue and config to defaults.
module terminal_escape_mouse_demux_unit (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [7:0]         in_data_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_key_byte,
  output logic signed [16:0] out_pointer_x,
  output logic signed [16:0] out_pointer_y,
  output logic               out_last_of_run,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import temd_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_empty, q_pop, f_push, take;
  cmd_t f_cmd, q_head;

  // Writes always taken; user must write only while the block is idle; not enforced
  assign cfg_ready = 1'b1;

  // Update the addressed register, masked to its width; drop unknown indexes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CELL_W:  cfg_nxt.cell_w  = cfg_data[6:0];
        CFG_CELL_H:  cfg_nxt.cell_h  = cfg_data[6:0];
        CFG_ORG_COL: cfg_nxt.org_col = cfg_data[9:0];
        CFG_ORG_ROW: cfg_nxt.org_row = cfg_data[9:0];
        CFG_IMG_W:   cfg_nxt.img_w   = cfg_data;
        CFG_IMG_H:   cfg_nxt.img_h   = cfg_data;
        CFG_TIMEOUT: cfg_nxt.timeout = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_w  <= 7'd9;
      cfg_r.cell_h  <= 7'd18;
      cfg_r.org_col <= 10'd1;
      cfg_r.org_row <= 10'd1;
      cfg_r.img_w   <= 13'd0;
      cfg_r.img_h   <= 13'd0;
      cfg_r.timeout <= 8'd25;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Hold the input side only while the command queue is full; every
  // transaction pushes at most one command, so this never loses one.
  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  temd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .opcode    (in_opcode),
    .data_byte (in_data_byte),
    .timeout   (cfg_r.timeout),
    .push      (f_push),
    .cmd       (f_cmd)
  );

  temd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_cmd (f_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Expand each command into its results and register them for the output
  temd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head            (q_head),
    .empty           (q_empty),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_key_byte    (out_key_byte),
    .out_pointer_x   (out_pointer_x),
    .out_pointer_y   (out_pointer_y),
    .out_last_of_run (out_last_of_run)
  );

endmodule

### hdl/temd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the demultiplexer, bound to the top level.
// Depends on temd_pkg.
module temd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_kind,
  input logic [7:0]         out_key_byte,
  input logic signed [16:0] out_pointer_x,
  input logic signed [16:0] out_pointer_y,
  input logic               out_last_of_run
);
  import temd_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_key_byte)
      && $stable(out_pointer_x) && $stable(out_pointer_y))
    else $error("stalled result changed");

  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FLUSH |-> out_key_byte == BYTE_ESC && out_last_of_run)
    else $error("escape flush malformed");

  a_mouse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PRESS || out_kind == KIND_MOVE)
      |-> out_last_of_run && out_key_byte == 8'd0)
    else $error("pointer event malformed");

  a_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_KEY || out_kind == KIND_FLUSH)
      |-> out_pointer_x == 17'sd0 && out_pointer_y == 17'sd0)
    else $error("key result carries a position");

endmodule

bind terminal_escape_mouse_demux_unit temd_checker u_temd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_key_byte    (out_key_byte),
  .out_pointer_x   (out_pointer_x),
  .out_pointer_y   (out_pointer_y),
  .out_last_of_run (out_last_of_run)
);
